// ----- src/tle_pkg.sv -----
// Shared types and constants for the terminal line editor with echo.
package tle_pkg;

   // Longest line the downstream line buffer is built for.
   localparam int LINE_MAX = 128;
   // The capacity register is 8 bits wide, so the limit never needs more.
   localparam logic [7:0] CAP_LIMIT = (LINE_MAX > 255) ? 8'd255 : 8'(LINE_MAX);
   localparam logic [7:0] CAP_RESET = 8'd128;

   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_SP  = 8'h20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Register index in the CSR map, taken from paddr[2].
   localparam logic CSR_IDX_LINE_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_BELL,
      CMD_ERASE,
      CMD_NEWLINE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_code;
      logic [7:0]   pos;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       store_valid;
      logic [7:0] store_index;
      logic [7:0] store_byte;
      logic       line_end;
      logic [7:0] line_length;
      logic       last;
   } result_type;

endpackage

// ----- src/tty_line_editor_echo.sv -----
// A byte's command passes the queue before its first echo is registered. Throughput:
// one result transaction per cycle from the single output register when rsp_tready is high;
// a backspace makes three results, a carriage return two, a stored or belled byte one.
// Input bytes are taken every cycle while the four-entry command queue has room.
// Reset (synchronous) clears the line position, the queue and the output register and
// sets line_capacity to 128.
module tty_line_editor_echo import tle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] echo_valid, [8:1] echo_byte, [9] store_valid, [17:10] store_index,
   // [25:18] store_byte, [26] line_end, [34:27] line_length, [39:35] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]       capacity_ff;
   logic [7:0]       capacity_in;
   logic             csr_write;
   logic             cmd_push;
   logic             cmd_pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type queue_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_LINE_CAPACITY) ? {24'b0, capacity_ff} : 32'b0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && csr_paddr[2] == CSR_IDX_LINE_CAPACITY) begin
         capacity_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   tle_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .capacity     (capacity_ff),
      .queue_status (queue_status),
      .cmd_push     (cmd_push),
      .cmd_out      (push_cmd)
   );

   tle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   tle_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_cmd     (head_cmd),
      .cmd_pop      (cmd_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ----- src/tle_front.sv -----
// Front end: accepts received bytes, tracks the line position and issues commands.
module tle_front import tle_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic [7:0]       capacity,
   input  queue_status_type queue_status,
   output logic             cmd_push,
   output cmd_type          cmd_out
);

   logic [7:0] position_ff;
   logic [7:0] position_in;
   logic [7:0] cap_eff;
   logic       accept;
   logic       drop;

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign cap_eff    = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;

   always_comb begin
      drop              = 1'b0;
      position_in       = position_ff;
      cmd_out.kind      = CMD_STORE;
      cmd_out.char_code = req_tdata;
      cmd_out.pos       = position_ff;
      if (req_tdata == CH_BS || req_tdata == CH_DEL) begin
         cmd_out.kind = CMD_ERASE;
         if (position_ff == 8'd0) begin
            drop = 1'b1;
         end else begin
            position_in = position_ff - 8'd1;
         end
      end else if (req_tdata == CH_ESC) begin
         drop = 1'b1;
      end else if (req_tdata == CH_CR) begin
         cmd_out.kind = CMD_NEWLINE;
         position_in  = 8'd0;
      end else if (position_ff >= cap_eff) begin
         cmd_out.kind = CMD_BELL;
      end else begin
         position_in = position_ff + 8'd1;
      end
   end

   assign cmd_push = accept && !drop;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 8'd0;
      end else if (accept) begin
         position_ff <= position_in;
      end
   end

endmodule

// ----- src/tle_queue.sv -----
// Short command queue that decouples the front end from the echo back end.
module tle_queue import tle_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff;
   logic [QUEUE_AW:0]   count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/tle_back.sv -----
// Back end: expands each command into its echo results behind an output register.
module tle_back import tle_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  cmd_type          head_cmd,
   output logic             cmd_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast
);

   typedef enum logic [1:0] {
      BEAT_FIRST,
      BEAT_SECOND,
      BEAT_THIRD
   } beat_type;

   beat_type   beat_ff;
   beat_type   beat_in;
   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   result_type result_in;
   logic       load;

   assign load = !queue_status.empty && (!valid_ff || rsp_tready);

   always_comb begin
      result_in            = '0;
      result_in.echo_valid = 1'b1;
      case (head_cmd.kind)
         CMD_STORE: begin
            result_in.echo_byte   = head_cmd.char_code;
            result_in.store_valid = 1'b1;
            result_in.store_index = head_cmd.pos;
            result_in.store_byte  = head_cmd.char_code;
            result_in.last        = 1'b1;
         end
         CMD_BELL: begin
            result_in.echo_byte = CH_BEL;
            result_in.last      = 1'b1;
         end
         CMD_ERASE: begin
            result_in.echo_byte = (beat_ff == BEAT_SECOND) ? CH_SP : CH_BS;
            result_in.last      = (beat_ff == BEAT_THIRD);
         end
         CMD_NEWLINE: begin
            if (beat_ff == BEAT_FIRST) begin
               result_in.echo_byte   = CH_CR;
               result_in.store_valid = 1'b1;
               result_in.store_index = head_cmd.pos;
               result_in.store_byte  = CH_LF;
            end else begin
               result_in.echo_byte   = CH_LF;
               result_in.line_end    = 1'b1;
               result_in.line_length = head_cmd.pos;
               result_in.last        = 1'b1;
            end
         end
         default: begin
            result_in.last = 1'b1;
         end
      endcase
   end

   // The command leaves the queue together with its final result.
   assign cmd_pop = load && result_in.last;

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         if (result_in.last) begin
            beat_in = BEAT_FIRST;
         end else begin
            case (beat_ff)
               BEAT_FIRST:  beat_in = BEAT_SECOND;
               BEAT_SECOND: beat_in = BEAT_THIRD;
               default:     beat_in = BEAT_FIRST;
            endcase
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff   <= BEAT_FIRST;
         valid_ff  <= 1'b0;
         result_ff <= '0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
         if (load) begin
            result_ff <= result_in;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = result_ff.last;
   assign rsp_tdata  = {5'b0, result_ff.line_length, result_ff.line_end,
                        result_ff.store_byte, result_ff.store_index,
                        result_ff.store_valid, result_ff.echo_byte,
                        result_ff.echo_valid};

endmodule

// ----- src/tle_checker.sv -----
// Port-level checks for the line editor, bound to the top level.
module tle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Every result carries an echo byte.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> rsp_tdata[0])
      else $error("result without echo_valid");

   // A store and a line end never share one result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[26]))
      else $error("store and line end in one result");

   // The line end is always the final result of its byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[26]) |-> rsp_tlast)
      else $error("line end without tlast");

   // A carriage return store is followed by its line end once taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tdata[9] && !rsp_tlast) |=>
      (rsp_tvalid && rsp_tdata[26]))
      else $error("newline store not followed by line end");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind tty_line_editor_echo tle_checker u_tle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- test/tb_tty_line_editor_echo.sv -----
`timescale 1ns / 100ps
// Testbench for the terminal line editor: predicts and checks echo, store and line-end results.
module tb_tty_line_editor_echo;
   import tle_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_PERIOD  = 48;
   localparam logic [2:0] ADDR_LINE_CAPACITY = {CSR_IDX_LINE_CAPACITY, 2'b00};

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_HICCUP} rx_stall_mode_type;

   // Tracks the line position and the echo transactions still owed by the block.
   class line_echo_scoreboard_type;
      logic [7:0] capacity;
      logic [7:0] position;
      result_type echo_q[$];
      int errors, items, results_seen, bells, erases, line_ends;

      function new();
         capacity = CAP_RESET;
         position = 8'd0;
      endfunction

      function int pending();
         return echo_q.size();
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t ns: %s", $time, what);
      endtask

      function void add_echo(logic [7:0] echo, logic sv, logic [7:0] si, logic [7:0] sb,
                             logic le, logic [7:0] ll, logic fin);
         result_type r;
         r.echo_valid  = 1'b1;
         r.echo_byte   = echo;
         r.store_valid = sv;
         r.store_index = si;
         r.store_byte  = sb;
         r.line_end    = le;
         r.line_length = ll;
         r.last        = fin;
         echo_q.push_back(r);
      endfunction

      function void note_input(logic [7:0] rx);
         logic [7:0] limit;
         limit = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
         items++;
         if (rx == CH_BS || rx == CH_DEL) begin
            // Erasing on an empty line is silent.
            if (position != 8'd0) begin
               position = position - 8'd1;
               erases++;
               add_echo(CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0);
               add_echo(CH_SP, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0);
               add_echo(CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1);
            end
         end else if (rx == CH_CR) begin
            // The newline lands at the current position, which may equal the capacity.
            add_echo(CH_CR, 1'b1, position, CH_LF, 1'b0, 8'd0, 1'b0);
            add_echo(CH_LF, 1'b0, 8'd0, 8'd0, 1'b1, position, 1'b1);
            position = 8'd0;
            line_ends++;
         end else if (rx != CH_ESC) begin
            if (position >= limit) begin
               add_echo(CH_BEL, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1);
               bells++;
            end else begin
               add_echo(rx, 1'b1, position, rx, 1'b0, 8'd0, 1'b1);
               position = position + 8'd1;
            end
         end
      endfunction

      task compare_field(string name, logic [7:0] got, logic [7:0] want_v);
         if (got !== want_v)
            report($sformatf("%s is %h, predicted %h", name, got, want_v));
      endtask

      task check_result(logic [39:0] data, logic tl);
         result_type want;
         results_seen++;
         if (echo_q.size() == 0) begin
            report($sformatf("result transaction %h with nothing predicted", data));
            return;
         end
         want = echo_q.pop_front();
         compare_field("echo_valid", 8'(data[0]), 8'(want.echo_valid));
         compare_field("echo_byte", data[8:1], want.echo_byte);
         compare_field("store_valid", 8'(data[9]), 8'(want.store_valid));
         compare_field("store_index", data[17:10], want.store_index);
         compare_field("store_byte", data[25:18], want.store_byte);
         compare_field("line_end", 8'(data[26]), 8'(want.line_end));
         compare_field("line_length", data[34:27], want.line_length);
         compare_field("padding", 8'(data[39:35]), 8'd0);
         compare_field("tlast", 8'(tl), 8'(want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] echo_valid, [8:1] echo_byte, [9] store_valid, [17:10] store_index,
   // [25:18] store_byte, [26] line_end, [34:27] line_length, [39:35] zero
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   line_echo_scoreboard_type board = new();
   int cycle_count = 0;
   int stall_tick = 0;
   rx_stall_mode_type stall_mode = RX_STEADY;
   int settings_used = 0;

   tty_line_editor_echo uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #(CLOCK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending());
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
   end

   // The receiver switches at random between back-pressure patterns.
   always @(negedge clock) begin
      if (stall_tick % STALL_PERIOD == 0)
         stall_mode = rx_stall_mode_type'($urandom_range(3));
      stall_tick++;
      case (stall_mode)
         RX_STEADY: rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= ($urandom_range(1) == 1);
         RX_SPARSE: rsp_tready <= (stall_tick % 4 == 0);
         default:   rsp_tready <= ($urandom_range(9) != 0);
      endcase
   end

   // Called at a falling edge; leaves tvalid high so a burst can continue.
   task automatic send_byte(input logic [7:0] rx);
      req_tdata  <= rx;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_input(rx);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int gap);
      req_tvalid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   // Holds the sender off until every predicted result has been seen.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [7:0] value);
      logic [31:0] readback;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_LINE_CAPACITY;
      csr_pwdata  <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.capacity = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_psel <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      if (readback[7:0] !== value)
         board.report($sformatf("line_capacity reads %h after writing %h", readback, value));
      settings_used++;
   endtask

   function automatic logic [7:0] pick_byte(input int erase_pct, input int cr_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < erase_pct) return ($urandom_range(1) == 1) ? CH_BS : CH_DEL;
      if (roll < erase_pct + cr_pct) return CH_CR;
      if (roll < erase_pct + cr_pct + 3) return CH_ESC;
      return 8'($urandom_range(255));
   endfunction

   initial begin
      logic [7:0] phase_cap;
      int phase_len, sent, burst, p;
      bit long_line;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Silent items on an empty line, an empty line end, then the byte extremes.
      send_byte(CH_ESC);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(CH_CR);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h41);
      send_byte(8'h80);
      send_byte(CH_LF);
      send_byte(CH_BEL);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(CH_CR);
      wait_drained();

      // A full line rings the bell and the newline goes into the extra slot.
      write_capacity(8'd2);
      send_byte(8'h61);
      send_byte(8'h62);
      send_byte(8'h63);
      send_byte(CH_CR);
      send_byte(8'h78);
      send_byte(8'h79);
      wait_drained();

      // Capacity lowered below the current position.
      write_capacity(8'd1);
      send_byte(8'h7A);
      send_byte(CH_BS);
      send_byte(8'h71);
      send_byte(CH_CR);
      wait_drained();

      write_capacity(8'd0);
      send_byte(8'h6B);
      send_byte(CH_CR);
      wait_drained();

      for (p = 0; p < 8; p++) begin
         case (p)
            0: phase_cap = 8'd3;
            1: phase_cap = 8'd1;
            2: phase_cap = 8'd0;
            3: phase_cap = 8'd128;
            4: phase_cap = 8'd255;
            5: phase_cap = 8'($urandom_range(4, 40));
            6: phase_cap = 8'd2;
            default: phase_cap = 8'($urandom_range(1, 127));
         endcase
         write_capacity(phase_cap);
         // Long lines without carriage returns to fill the full buffer.
         long_line = (phase_cap >= CAP_LIMIT);
         phase_len = long_line ? 160 : 18;
         sent = 0;
         while (sent < phase_len) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < phase_len) begin
               send_byte(long_line ? pick_byte(4, 0) : pick_byte(15, 15));
               sent++;
               burst--;
            end
            if ($urandom_range(24) == 0) wait_drained();
            else if ($urandom_range(9) >= 3) idle_sender($urandom_range(1, 6));
         end
         wait_drained();
      end

      $display("Sent %0d received bytes under %0d capacity settings; %0d echo %s",
               board.items, settings_used + 1, board.results_seen,
               "transactions checked.");
      $display("Predicted %0d bells, %0d erases and %0d completed lines.",
               board.bells, board.erases, board.line_ends);
      if (board.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- tty_line_editor_echo.f -----
src/tle_pkg.sv
src/tle_front.sv
src/tle_queue.sv
src/tle_back.sv
src/tty_line_editor_echo.sv
src/tle_checker.sv
test/tb_tty_line_editor_echo.sv
